FILE: rtl/dcd_pkg.sv
// Package: shared types and constants for the double clap detector.
`timescale 1ns / 1ps

package dcd_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned CSR_W   = 16;
   localparam int unsigned CSR_IDX_W = 3;

   typedef logic [TIME_W-1:0]    time_type;
   typedef logic [CSR_W-1:0]     csr_data_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_SILENCE_MIN = 3'd0;
   localparam csr_index_type CSR_SOUND_MAX   = 3'd1;
   localparam csr_index_type CSR_COOLDOWN    = 3'd2;
   localparam csr_index_type CSR_DOUBLE_MIN  = 3'd3;
   localparam csr_index_type CSR_DOUBLE_MAX  = 3'd4;

   localparam csr_data_type RST_SILENCE_MIN = 16'd50;
   localparam csr_data_type RST_SOUND_MAX   = 16'd200;
   localparam csr_data_type RST_COOLDOWN    = 16'd100;
   localparam csr_data_type RST_DOUBLE_MIN  = 16'd100;
   localparam csr_data_type RST_DOUBLE_MAX  = 16'd1000;

   localparam time_type TIME_NONE = 32'd0;

endpackage

FILE: rtl/dcd_req_if.sv
// Interface: poll channel carrying timestamp and comparator level.
`timescale 1ns / 1ps

interface dcd_req_if
   import dcd_pkg::*;
   ();
   logic     valid;
   logic     ready;
   time_type now_ms;
   logic     sensor_level;

   modport source (output valid, output now_ms, output sensor_level, input ready);
   modport sink   (input valid, input now_ms, input sensor_level, output ready);
endinterface

FILE: rtl/dcd_rsp_if.sv
// Interface: result channel carrying clap and double clap flags.
`timescale 1ns / 1ps

interface dcd_rsp_if;
   logic valid;
   logic ready;
   logic clap_detected;
   logic double_clap;

   modport source (output valid, output clap_detected, output double_clap, input ready);
   modport sink   (input valid, input clap_detected, input double_clap, output ready);
endinterface

FILE: rtl/double_clap_detector_core.sv
// Top level: double clap detector with poll input register and result register.
//
//   channel   | dir | handshake       | payload
//   ----------+-----+-----------------+-------------------------------------
//   req_chan  | in  | valid / ready   | now_ms[31:0], sensor_level
//   rsp_chan  | out | valid / ready   | clap_detected, double_clap
//   csr_*     | in  | csr_we          | csr_index[2:0], csr_wdata[15:0]
//
// One poll per cycle unless rsp_chan stalls; each poll passes the poll register and
// then the result register before rsp_chan offers its result. The two registers each
// hold one transaction, so a new poll is taken while an earlier result still waits on
// rsp_chan. Detector state updates as a poll moves from the poll register into the
// result register. Synchronous reset restores registers and clears all time stores.
`timescale 1ns / 1ps

module double_clap_detector_core
   import dcd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   dcd_req_if.sink       req_chan,
   dcd_rsp_if.source     rsp_chan,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_wdata
);

   csr_data_type silence_min_ff, sound_max_ff, cooldown_ff, double_min_ff, double_max_ff;

   logic     p_valid_ff;
   time_type p_now_ff;
   logic     p_level_ff;

   logic     prev_level_ff, prev_level_in;
   time_type burst_start_ff, burst_start_in;
   time_type burst_last_ff, burst_last_in;
   time_type cooldown_end_ff, cooldown_end_in;
   time_type first_clap_ff, first_clap_in;

   logic rsp_valid_ff;
   logic clap_ff, clap_in;
   logic dbl_ff, dbl_in;

   logic     advance;
   logic     req_fire;
   time_type interval;
   logic     in_cooldown;
   logic     restart;
   time_type first_kept;

   assign advance  = p_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !p_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         silence_min_ff <= RST_SILENCE_MIN;
         sound_max_ff   <= RST_SOUND_MAX;
         cooldown_ff    <= RST_COOLDOWN;
         double_min_ff  <= RST_DOUBLE_MIN;
         double_max_ff  <= RST_DOUBLE_MAX;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SILENCE_MIN: silence_min_ff <= csr_wdata;
            CSR_SOUND_MAX:   sound_max_ff   <= csr_wdata;
            CSR_COOLDOWN:    cooldown_ff    <= csr_wdata;
            CSR_DOUBLE_MIN:  double_min_ff  <= csr_wdata;
            CSR_DOUBLE_MAX:  double_max_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // poll register
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         p_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         p_now_ff   <= req_chan.now_ms;
         p_level_ff <= req_chan.sensor_level;
      end
   end

   always_comb begin
      interval        = (first_clap_ff != TIME_NONE) ? p_now_ff - first_clap_ff : TIME_NONE;
      first_kept      = (interval > {16'd0, double_max_ff}) ? TIME_NONE : first_clap_ff;
      in_cooldown     = (cooldown_end_ff != TIME_NONE) && (p_now_ff < cooldown_end_ff);
      restart         = (burst_start_ff == TIME_NONE) ||
                        ((p_now_ff - burst_start_ff) > {16'd0, silence_min_ff});

      prev_level_in   = prev_level_ff;
      burst_start_in  = burst_start_ff;
      burst_last_in   = burst_last_ff;
      cooldown_end_in = cooldown_end_ff;
      first_clap_in   = first_kept;
      clap_in         = 1'b0;
      dbl_in          = 1'b0;

      if (!in_cooldown) begin
         prev_level_in = p_level_ff;
         if ((p_level_ff != prev_level_ff) && !p_level_ff) begin
            if (restart) begin
               burst_start_in  = p_now_ff;
               cooldown_end_in = TIME_NONE;
            end
            burst_last_in = p_now_ff;
         end
         if (p_level_ff && (burst_last_ff != TIME_NONE) &&
             ((p_now_ff - burst_last_ff) > {16'd0, silence_min_ff}) &&
             ((burst_last_ff - burst_start_ff) < {16'd0, sound_max_ff})) begin
            clap_in         = 1'b1;
            burst_start_in  = TIME_NONE;
            burst_last_in   = TIME_NONE;
            cooldown_end_in = p_now_ff + {16'd0, cooldown_ff};
         end
      end

      if (clap_in) begin
         if (first_kept == TIME_NONE) begin
            first_clap_in = p_now_ff;
         end else begin
            dbl_in = (interval > {16'd0, double_min_ff}) &&
                     (interval < {16'd0, double_max_ff});
            first_clap_in = TIME_NONE;
         end
      end
   end

   // detector state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff   <= 1'b1;
         burst_start_ff  <= TIME_NONE;
         burst_last_ff   <= TIME_NONE;
         cooldown_end_ff <= TIME_NONE;
         first_clap_ff   <= TIME_NONE;
      end else if (advance) begin
         prev_level_ff   <= prev_level_in;
         burst_start_ff  <= burst_start_in;
         burst_last_ff   <= burst_last_in;
         cooldown_end_ff <= cooldown_end_in;
         first_clap_ff   <= first_clap_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         clap_ff <= clap_in;
         dbl_ff  <= dbl_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.clap_detected = clap_ff;
   assign rsp_chan.double_clap   = dbl_ff;

   a_double_needs_clap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && dbl_ff |-> clap_ff)
      else $error("double clap without clap");

   a_clap_clears_burst: assert property (@(posedge clock) disable iff (reset)
      advance && clap_in |=> (burst_last_ff == TIME_NONE) && (burst_start_ff == TIME_NONE))
      else $error("burst not cleared after clap");

   a_cooldown_holds_level: assert property (@(posedge clock) disable iff (reset)
      advance && in_cooldown |=> $stable(prev_level_ff) && !clap_ff)
      else $error("level or clap changed during cooldown");

   a_stall_blocks_poll: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff && rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("poll taken while both stages are full");

endmodule

FILE: bench/dcd_clap_checker.sv
// Checker: watches the poll and result channels, predicts clap flags, compares them.
`timescale 1ns / 1ps

module dcd_clap_checker
   import dcd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   dcd_req_if            req_mon,
   dcd_rsp_if            rsp_mon,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_wdata,
   output int unsigned   mismatches,
   output int unsigned   awaiting,
   output int unsigned   claps_seen,
   output int unsigned   doubles_seen
);

   typedef struct packed {
      logic clap;
      logic dbl;
   } clap_flags_type;

   csr_data_type   silence_min;
   csr_data_type   sound_max;
   csr_data_type   cooldown_len;
   csr_data_type   double_min;
   csr_data_type   double_max;

   logic           level_q;
   time_type       burst_start;
   time_type       burst_last;
   time_type       cooldown_end;
   time_type       first_clap;

   clap_flags_type flags_due[$];

   initial begin
      mismatches   = 0;
      awaiting     = 0;
      claps_seen   = 0;
      doubles_seen = 0;
   end

   task automatic report_mismatch(input string what, input clap_flags_type want,
                                  input clap_flags_type seen);
      if (mismatches < 100) begin
         $display("%0t: %s: expected clap %0b double %0b, saw clap %0b double %0b",
                  $time, what, want.clap, want.dbl, seen.clap, seen.dbl);
      end
      mismatches++;
   endtask

   task automatic predict_poll(input time_type now, input logic level,
                               output clap_flags_type res);
      time_type since_first;
      logic     heard;
      since_first = TIME_NONE;
      heard       = 1'b0;
      res         = '0;
      if (first_clap != TIME_NONE) since_first = now - first_clap;
      if (since_first > double_max) first_clap = TIME_NONE;
      // plain comparison: a cooldown does not wrap
      if (!(cooldown_end != TIME_NONE && now < cooldown_end)) begin
         if (level != level_q) begin
            level_q = level;
            if (!level) begin
               if (burst_start == TIME_NONE || time_type'(now - burst_start) > silence_min) begin
                  burst_start  = now;
                  cooldown_end = TIME_NONE;
               end
               burst_last = now;
            end
         end
         if (level && burst_last != TIME_NONE &&
             time_type'(now - burst_last) > silence_min &&
             time_type'(burst_last - burst_start) < sound_max) begin
            burst_start  = TIME_NONE;
            burst_last   = TIME_NONE;
            cooldown_end = now + cooldown_len;
            heard        = 1'b1;
         end
      end
      if (heard) begin
         res.clap = 1'b1;
         if (first_clap == TIME_NONE) begin
            first_clap = now;
         end else begin
            res.dbl    = (since_first > double_min) && (since_first < double_max);
            first_clap = TIME_NONE;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      clap_flags_type fresh;
      clap_flags_type seen;
      clap_flags_type want;
      if (reset) begin
         silence_min  = RST_SILENCE_MIN;
         sound_max    = RST_SOUND_MAX;
         cooldown_len = RST_COOLDOWN;
         double_min   = RST_DOUBLE_MIN;
         double_max   = RST_DOUBLE_MAX;
         level_q      = 1'b1;
         burst_start  = TIME_NONE;
         burst_last   = TIME_NONE;
         cooldown_end = TIME_NONE;
         first_clap   = TIME_NONE;
         flags_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SILENCE_MIN: silence_min  = csr_wdata;
               CSR_SOUND_MAX:   sound_max    = csr_wdata;
               CSR_COOLDOWN:    cooldown_len = csr_wdata;
               CSR_DOUBLE_MIN:  double_min   = csr_wdata;
               CSR_DOUBLE_MAX:  double_max   = csr_wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_poll(req_mon.now_ms, req_mon.sensor_level, fresh);
            flags_due.push_back(fresh);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.clap = rsp_mon.clap_detected;
            seen.dbl  = rsp_mon.double_clap;
            if (flags_due.size() == 0) begin
               report_mismatch("result transaction with no poll waiting", '0, seen);
            end else begin
               want = flags_due.pop_front();
               if (seen.clap !== want.clap) report_mismatch("clap_detected differs", want, seen);
               if (seen.dbl !== want.dbl) report_mismatch("double_clap differs", want, seen);
               if (want.clap) claps_seen++;
               if (want.dbl) doubles_seen++;
            end
         end
      end
      awaiting = flags_due.size();
   end

endmodule

FILE: bench/double_clap_detector_core_test.sv
// Testbench top: drives polls and register writes into the detector and gives the verdict.
`timescale 1ns / 1ps

module double_clap_detector_core_test;
   import dcd_pkg::*;

   localparam time_type      TIME_LAST      = '1;
   localparam csr_index_type CSR_LAST_INDEX = '1;

   logic          clock;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   dcd_req_if req_chan ();
   dcd_rsp_if rsp_chan ();

   int unsigned   mismatches;
   int unsigned   awaiting;
   int unsigned   claps_seen;
   int unsigned   doubles_seen;

   time_type      now_t;
   csr_data_type  silence_min;
   csr_data_type  sound_max;
   csr_data_type  cooldown_len;
   csr_data_type  double_min;
   csr_data_type  double_max;
   int unsigned   polls_sent;
   int unsigned   settings_done;
   int unsigned   idle_odds;

   double_clap_detector_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dcd_clap_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .awaiting     (awaiting),
      .claps_seen   (claps_seen),
      .doubles_seen (doubles_seen)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int unsigned stall;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
            stall          = $urandom_range(1, 12);
            rsp_chan.ready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   task automatic send_poll(input logic level);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_chan.valid        = 1'b1;
      req_chan.now_ms       = now_t;
      req_chan.sensor_level = level;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      polls_sent++;
   endtask

   task automatic poll(input int unsigned dt, input logic level);
      now_t = now_t + dt;
      send_poll(level);
   endtask

   task automatic poll_at(input time_type t, input logic level);
      now_t = t;
      send_poll(level);
   endtask

   // step forward to the target, or by one if it is already reached or lies behind
   task automatic poll_until(input time_type target, input logic level);
      time_type delta;
      delta = target - now_t;
      if (delta == 0 || delta[31]) delta = 1;
      poll(delta, level);
   endtask

   task automatic drain();
      req_chan.valid = 1'b0;
      while (awaiting != 0) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input csr_data_type data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
   endtask

   task automatic apply_settings(input csr_data_type s, input csr_data_type n,
                                 input csr_data_type c, input csr_data_type lo,
                                 input csr_data_type hi);
      write_reg(csr_index_type'($urandom_range(CSR_DOUBLE_MAX + 1, CSR_LAST_INDEX)),
                csr_data_type'($urandom));
      write_reg(CSR_SILENCE_MIN, s);
      write_reg(CSR_SOUND_MAX, n);
      write_reg(CSR_COOLDOWN, c);
      write_reg(CSR_DOUBLE_MIN, lo);
      write_reg(CSR_DOUBLE_MAX, hi);
      csr_we = 1'b0;
      @(negedge clock);
      silence_min  = s;
      sound_max    = n;
      cooldown_len = c;
      double_min   = lo;
      double_max   = hi;
      settings_done++;
   endtask

   function automatic int unsigned pick_lead();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, cooldown_len + 2);
         1:       return cooldown_len + $urandom_range(1, 20);
         2:       return $urandom_range(1, 2 * silence_min + 2);
         default: return $urandom_range(double_max, 2 * double_max + 2);
      endcase
   endfunction

   task automatic clap_burst(input int unsigned lead);
      int unsigned span;
      time_type    fall_t;
      poll(lead, 1'b0);
      fall_t = now_t;
      span   = ($urandom_range(0, 3) == 0) ? silence_min + sound_max + 2 : silence_min / 2 + 1;
      repeat ($urandom_range(0, 3)) begin
         poll($urandom_range(1, span), 1'b1);
         poll($urandom_range(1, span), 1'b0);
         fall_t = now_t;
      end
      poll($urandom_range(1, span), 1'b1);
      if ($urandom_range(0, 2) == 0) poll(1, 1'b1);
      poll_until(fall_t + silence_min + $urandom_range(0, 3), 1'b1);
   endtask

   task automatic run_episodes(input int unsigned count);
      int unsigned goal;
      int unsigned pick;
      longint      gap;
      time_type    first_t;
      time_type    jump_t;
      time_type    resume_t;
      goal = polls_sent + count;
      while (polls_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            clap_burst(pick_lead());
         end else if (pick < 80) begin
            clap_burst(pick_lead());
            first_t = now_t;
            case ($urandom_range(0, 6))
               0:       gap = double_min;
               1:       gap = longint'(double_min) + 1;
               2:       gap = longint'(double_max) - 1;
               3:       gap = double_max;
               4:       gap = longint'(double_max) + 1;
               5:       gap = $urandom_range(double_min, double_max);
               default: gap = $urandom_range(0, 2 * double_max + 2);
            endcase
            if ($urandom_range(0, 3) == 0) begin
               poll($urandom_range(0, cooldown_len), 1'($urandom_range(0, 1)));
            end
            poll_until(first_t + time_type'(gap - longint'(silence_min) - 2), 1'b0);
            poll($urandom_range(1, 2), 1'b1);
            poll_until(first_t + time_type'(gap), 1'b1);
         end else if (pick < 94) begin
            repeat ($urandom_range(1, 6)) begin
               poll($urandom_range(0, silence_min + 5), 1'($urandom_range(0, 1)));
            end
         end else begin
            // cross the wrap of the time base, then clear any cooldown left behind
            jump_t = TIME_LAST - $urandom_range(0, silence_min + 300);
            if (now_t < jump_t) poll_at(jump_t, 1'b1);
            clap_burst($urandom_range(0, 40));
            if (now_t[31]) poll_until(TIME_NONE, 1'($urandom_range(0, 1)));
            resume_t = now_t;
            poll_at(TIME_LAST, 1'b1);
            poll_at(TIME_LAST, 1'b0);
            now_t = resume_t;
         end
      end
   endtask

   initial begin
      int unsigned waited;
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = CSR_SILENCE_MIN;
      csr_wdata             = '0;
      req_chan.valid        = 1'b0;
      req_chan.now_ms       = TIME_NONE;
      req_chan.sensor_level = 1'b1;
      idle_odds             = 4;
      polls_sent            = 0;
      settings_done         = 1;
      now_t                 = TIME_NONE;
      silence_min           = RST_SILENCE_MIN;
      sound_max             = RST_SOUND_MAX;
      cooldown_len          = RST_COOLDOWN;
      double_min            = RST_DOUBLE_MIN;
      double_max            = RST_DOUBLE_MAX;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero timestamps, silence boundary, cooldown edge, double window, pair expiry, wrap
      poll_at(32'd0, 1'b1);
      poll_at(32'd0, 1'b0);
      poll_at(32'd5, 1'b1);
      poll_at(32'd1000, 1'b0);
      poll_at(32'd1010, 1'b1);
      poll_at(32'd1020, 1'b0);
      poll_at(32'd1030, 1'b1);
      poll_at(32'd1070, 1'b1);
      poll_at(32'd1071, 1'b1);
      poll_at(32'd1170, 1'b0);
      poll_at(32'd1171, 1'b0);
      poll_at(32'd1172, 1'b1);
      poll_at(32'd1222, 1'b1);
      poll_at(32'd1400, 1'b0);
      poll_at(32'd1401, 1'b1);
      poll_at(32'd1452, 1'b1);
      poll_at(32'd2453, 1'b0);
      poll_at(32'd2454, 1'b1);
      poll_at(32'd2505, 1'b1);
      poll_at(32'hFFFF_FE00, 1'b0);
      poll_at(32'hFFFF_FE01, 1'b1);
      poll_at(32'hFFFF_FF9C, 1'b1);
      poll_at(32'hFFFF_FFA0, 1'b0);
      poll_at(32'hFFFF_FFA1, 1'b1);
      poll_at(TIME_LAST, 1'b0);
      poll_at(32'd0, 1'b1);
      poll_at(32'd52, 1'b1);

      run_episodes(120);
      for (int p = 0; p < 6; p++) begin
         drain();
         idle_odds = (p == 2) ? 0 : 3 + p;
         case (p)
            0: apply_settings('0, '0, '0, '0, '0);
            1: apply_settings('0, 16'd1, '0, '0, 16'd2);
            2: apply_settings('1, '1, '1, '1, '1);
            3: apply_settings(16'd300, 16'd40, 16'd20, 16'd50, 16'd600);
            default: apply_settings(csr_data_type'($urandom_range(0, 2000)),
                                    csr_data_type'($urandom_range(0, 2000)),
                                    csr_data_type'($urandom_range(0, 2000)),
                                    csr_data_type'($urandom_range(0, 2000)),
                                    csr_data_type'($urandom_range(0, 2000)));
         endcase
         run_episodes((p == 0) ? 60 : 150);
      end

      drain();
      idle_odds = 0;
      apply_settings(RST_SILENCE_MIN, RST_SOUND_MAX, RST_COOLDOWN, RST_DOUBLE_MIN,
                     RST_DOUBLE_MAX);
      run_episodes(180);

      req_chan.valid = 1'b0;
      waited         = 0;
      while (awaiting != 0 && waited < 500) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);

      $display("Covered %0d polls under %0d register settings, with idle and stall bursts",
               polls_sent, settings_done);
      $display("Claps completed: %0d, of which double claps: %0d", claps_seen, doubles_seen);
      if (awaiting != 0) $display("%0d result transactions never arrived", awaiting);
      if (mismatches == 0 && awaiting == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
